// File: src/wrms_pkg.sv
package wrms_pkg;

  // Converter sample width and the widths that follow from it.
  localparam int SAMPLE_BITS = 12;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;

  // Window and gain registers.
  localparam int WIN_BITS      = 8;
  localparam int GAIN_BITS     = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [WIN_BITS-1:0]  WIN_RESET  = 8'd200;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 20'd93240;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VOLT_GAIN     = 2'd1;

  // Accumulator and result widths.
  localparam int ACC_BITS  = 31;
  localparam int SUM_BITS  = 30;
  localparam int RMS_BITS  = 20;
  localparam int VOLT_BITS = 23;
  localparam int FRAC_BITS = 16;

  // Long division of sum * 2^16 by the window, one quotient bit a cycle.
  localparam int DIV_STEPS = ACC_BITS + FRAC_BITS;
  // Square root of the quotient, two radicand bits a cycle.
  localparam int SQRT_STEPS = (DIV_STEPS + 1) / 2;
  localparam int RAD_BITS   = 2 * SQRT_STEPS;
  localparam int ROOT_BITS  = SQRT_STEPS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam int PROD_BITS = RMS_BITS + GAIN_BITS;

  // Queue between the accumulator and the arithmetic back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // One finished window waiting for its division and square root.
  typedef struct packed {
    logic [ACC_BITS-1:0] sum;
    logic [WIN_BITS-1:0] win;
  } job_t;

endpackage

// File: src/wrms_front.sv
module wrms_front
  import wrms_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_valid_i,
  output logic                   sample_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [WIN_BITS-1:0]    window_length_i,
  input  logic [QCNT_BITS-1:0]   queue_count_i,
  output logic                   push_o,
  output job_t                   job_o
);

  logic                   sq_valid_q;
  logic [SQ_BITS-1:0]     sq_q, sq_d;
  logic [SAMPLE_BITS-1:0] mag;
  logic [ACC_BITS-1:0]    acc_q, acc_d, acc_sat;
  logic [ACC_BITS:0]      acc_sum;
  logic [WIN_BITS-1:0]    cnt_q, cnt_d, win;
  logic [WIN_BITS:0]      cnt_inc;
  logic                   accept, close;

  // A window may close for the beat already squared; hold off unless the
  // queue has room for that one and for the next.
  assign sample_stall_o = (queue_count_i + QCNT_BITS'(sq_valid_q)) >= QCNT_BITS'(QUEUE_DEPTH);
  assign accept         = sample_valid_i && !sample_stall_o;

  // Magnitude of the two's complement sample, then its square.
  assign mag  = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
  assign sq_d = SQ_BITS'(mag) * SQ_BITS'(mag);

  // Saturating accumulate and window count.
  assign acc_sum = {1'b0, acc_q} + (ACC_BITS + 1)'(sq_q);
  assign acc_sat = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];
  assign win     = (window_length_i == '0) ? WIN_BITS'(1) : window_length_i;
  assign cnt_inc = {1'b0, cnt_q} + (WIN_BITS + 1)'(1);
  assign close   = sq_valid_q && (cnt_inc >= {1'b0, win});

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (sq_valid_q) begin
      if (close) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = acc_sat;
        cnt_d = cnt_inc[WIN_BITS-1:0];
      end
    end
  end

  assign push_o    = close;
  assign job_o.sum = acc_sat;
  assign job_o.win = win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      acc_q      <= '0;
      cnt_q      <= '0;
    end else begin
      sq_valid_q <= accept;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q <= sq_d;
    end
  end

endmodule

// File: src/wrms_queue.sv
module wrms_queue
  import wrms_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  job_t                 job_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [QCNT_BITS-1:0] count_o,
  output job_t                 job_o
);

  job_t                 slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign job_o   = slot_q[rd_q];

  // Pointers and fill count; the front never pushes into a full queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_BITS'(push_i) - QCNT_BITS'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

// File: src/wrms_back.sv
module wrms_back
  import wrms_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  job_t                 job_i,
  output logic                 pop_o,
  input  logic [GAIN_BITS-1:0] volt_gain_i,
  output logic                 result_valid_o,
  input  logic                 result_stall_i,
  output logic [SUM_BITS-1:0]  sum_of_squares_o,
  output logic [RMS_BITS-1:0]  rms_counts_q8_o,
  output logic [VOLT_BITS-1:0] rms_volts_q8_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [STEP_BITS-1:0] step_q;
  logic [ACC_BITS-1:0]  sum_q;
  logic [WIN_BITS-1:0]  win_q;
  logic [DIV_STEPS-1:0] dvd_q;
  logic [WIN_BITS-1:0]  drem_q;
  logic [RAD_BITS-1:0]  rad_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [REM_BITS-1:0]  srem_q;
  logic [PROD_BITS-1:0] prod_q;
  logic                 out_valid_q;
  logic [SUM_BITS-1:0]  out_sum_q;
  logic [RMS_BITS-1:0]  out_rms_q;
  logic [VOLT_BITS-1:0] out_volt_q;

  logic [WIN_BITS:0]    drem_shift, drem_diff;
  logic                 div_ge;
  logic [REM_BITS+1:0]  srem_shift, srem_diff, trial;
  logic                 sqrt_ge;
  logic [RMS_BITS-1:0]  rms_sat;
  logic                 out_free;

  // Restoring division step: one quotient bit shifts into the dividend.
  assign drem_shift = {drem_q, dvd_q[DIV_STEPS-1]};
  assign div_ge     = drem_shift >= {1'b0, win_q};
  assign drem_diff  = drem_shift - {1'b0, win_q};

  // Digit-by-digit square root step.
  assign srem_shift = {srem_q, rad_q[RAD_BITS-1 -: 2]};
  assign trial      = (REM_BITS + 2)'({root_q, 2'b01});
  assign sqrt_ge    = srem_shift >= trial;
  assign srem_diff  = srem_shift - trial;

  assign rms_sat  = (root_q[ROOT_BITS-1:RMS_BITS] != '0) ? {RMS_BITS{1'b1}}
                                                         : root_q[RMS_BITS-1:0];
  assign out_free = !out_valid_q || !result_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output beat is loaded when the result is done and held while stalled.
      out_valid_q <= ((state_q == ST_FIN) && out_free) || (out_valid_q && result_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_SQRT: begin
          if (step_q == STEP_BITS'(SQRT_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= ST_MUL;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the arithmetic sequence.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          sum_q  <= job_i.sum;
          win_q  <= job_i.win;
          dvd_q  <= {job_i.sum, {FRAC_BITS{1'b0}}};
          drem_q <= '0;
        end
      end
      ST_DIV: begin
        drem_q <= div_ge ? drem_diff[WIN_BITS-1:0] : drem_shift[WIN_BITS-1:0];
        dvd_q  <= {dvd_q[DIV_STEPS-2:0], div_ge};
        if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
          rad_q  <= RAD_BITS'({dvd_q[DIV_STEPS-2:0], div_ge});
          root_q <= '0;
          srem_q <= '0;
        end
      end
      ST_SQRT: begin
        rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
        srem_q <= sqrt_ge ? srem_diff[REM_BITS-1:0] : srem_shift[REM_BITS-1:0];
        root_q <= {root_q[ROOT_BITS-2:0], sqrt_ge};
      end
      ST_MUL: begin
        prod_q <= PROD_BITS'(rms_sat) * PROD_BITS'(volt_gain_i);
      end
      ST_FIN: begin
        if (out_free) begin
          out_sum_q  <= sum_q[ACC_BITS-1] ? {SUM_BITS{1'b1}} : sum_q[SUM_BITS-1:0];
          out_rms_q  <= rms_sat;
          out_volt_q <= prod_q[PROD_BITS-1] ? {VOLT_BITS{1'b1}}
                                            : prod_q[PROD_BITS-2:FRAC_BITS];
        end
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  assign result_valid_o   = out_valid_q;
  assign sum_of_squares_o = out_sum_q;
  assign rms_counts_q8_o  = out_rms_q;
  assign rms_volts_q8_o   = out_volt_q;

endmodule

// File: src/windowed_rms_meter.sv
// Windowed true-RMS meter.
// Input channel: one signed converter sample per beat on sample_i, moved when
// sample_valid_i is high and sample_stall_o is low. Output channel: one beat per
// finished window with the sum of squares, the RMS in counts (8 fraction bits)
// and the RMS in volts (8 fraction bits), moved when result_valid_o is high
// and result_stall_i is low.
// Configuration: cfg_we_i writes cfg_data_i to the register chosen by cfg_idx_i
// (0: window length, 1: volt gain). Write only while the block is idle.
// Throughput: the accumulator takes one sample every cycle while sample_stall_o
// is low. The back end works on one window at a time, through the 47-step long
// division and the 24-step square root; windows that close faster than the back
// end finishes them stall the input once the two-entry job queue is full.
// Result path: the queued job goes through division, square root and multiply
// before the result beat, plus any wait for an earlier result still stalled.
// Reset: clears count, accumulator, queue and output valid; window length
// returns to 200 and volt gain to 93240. A stalled result holds its payload,
// and the back end waits with its next result until the output is taken.
module windowed_rms_meter
  import wrms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     sample_valid_i,
  output logic                     sample_stall_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     result_valid_o,
  input  logic                     result_stall_i,
  output logic [SUM_BITS-1:0]      sum_of_squares_o,
  output logic [RMS_BITS-1:0]      rms_counts_q8_o,
  output logic [VOLT_BITS-1:0]     rms_volts_q8_o
);

  logic [WIN_BITS-1:0]  window_length_q;
  logic [GAIN_BITS-1:0] volt_gain_q;
  logic                 push, pop, empty;
  logic [QCNT_BITS-1:0] queue_count;
  job_t                 front_job, queue_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WIN_RESET;
      volt_gain_q     <= GAIN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WINDOW_LENGTH) begin
        window_length_q <= cfg_data_i[WIN_BITS-1:0];
      end
      if (cfg_idx_i == CFG_VOLT_GAIN) begin
        volt_gain_q <= cfg_data_i[GAIN_BITS-1:0];
      end
    end
  end

  wrms_front u_front (
    .clk_i,
    .rst_ni,
    .sample_valid_i,
    .sample_stall_o,
    .sample_i,
    .window_length_i (window_length_q),
    .queue_count_i   (queue_count),
    .push_o          (push),
    .job_o           (front_job)
  );

  wrms_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .empty_o (empty),
    .count_o (queue_count),
    .job_o   (queue_job)
  );

  wrms_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (empty),
    .job_i       (queue_job),
    .pop_o       (pop),
    .volt_gain_i (volt_gain_q),
    .result_valid_o,
    .result_stall_i,
    .sum_of_squares_o,
    .rms_counts_q8_o,
    .rms_volts_q8_o
  );

endmodule

// File: src/wrms_checker.sv
module wrms_port_checker
  import wrms_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 result_valid_o,
  input logic                 result_stall_i,
  input logic [SUM_BITS-1:0]  sum_of_squares_o,
  input logic [RMS_BITS-1:0]  rms_counts_q8_o,
  input logic [VOLT_BITS-1:0] rms_volts_q8_o
);

  // A stalled result beat stays and keeps its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(sum_of_squares_o)
      && $stable(rms_counts_q8_o) && $stable(rms_volts_q8_o))
    else $error("stalled result changed");

  // A silent window has zero RMS.
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (sum_of_squares_o == '0) |-> (rms_counts_q8_o == '0))
    else $error("nonzero RMS from a zero sum");

  // Zero RMS scales to zero volts.
  a_zero_volts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (rms_counts_q8_o == '0) |-> (rms_volts_q8_o == '0))
    else $error("nonzero volts from zero RMS");

  // A nonzero sum can never round to zero RMS: sum * 2^16 / window is at least 257.
  a_nonzero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (sum_of_squares_o != '0) |-> (rms_counts_q8_o != '0))
    else $error("zero RMS from a nonzero sum");

endmodule

bind windowed_rms_meter wrms_port_checker u_wrms_checker (
  .clk_i,
  .rst_ni,
  .result_valid_o,
  .result_stall_i,
  .sum_of_squares_o,
  .rms_counts_q8_o,
  .rms_volts_q8_o
);
